[hw/rtl/mfd_pkg.sv]
// Shared types and constants for the measurement frame deframer.
`default_nettype none

package mfd_pkg;

    // Start and end marker byte of a frame
    localparam logic [7:0] FRAME_MARK = 8'hAA;

    // Result status codes
    localparam logic STATUS_POINT    = 1'b0;
    localparam logic STATUS_MARK_ERR = 1'b1;

    // Result queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register byte address (word index lives in paddr[2])
    localparam int unsigned PADDR_W          = 3;
    localparam logic        REG_EXPECTED_IDX = 1'b0;

    // Position within the 8-byte frame
    typedef enum logic [2:0] {
        POS_HUNT,
        POS_DURATION,
        POS_FREQ0,
        POS_FREQ1,
        POS_FREQ2,
        POS_FREQ3,
        POS_END_MARK,
        POS_CHECKSUM
    } t_frame_pos;

    // One result item as it travels from front to back
    typedef struct packed {
        logic        frame_status;
        logic [7:0]  duration;
        logic [31:0] frequency;
        logic [15:0] point_index;
        logic        run_done;
    } t_result;

endpackage

`default_nettype wire

[hw/rtl/mfd_front.sv]
// Front part: frame hunting, byte gathering, point counting and result build.
`default_nettype none

module mfd_front
    import mfd_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_byte_valid,
    input  wire logic [7:0]  i_byte,
    input  wire logic [15:0] i_expected_points,
    output t_result          o_push_data,
    output logic             o_push
);

    localparam int unsigned CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    t_frame_pos              r_pos;
    t_frame_pos              n_pos;
    logic [7:0]              r_duration;
    logic [31:0]             r_frequency;
    logic [7:0]              r_end_mark;
    logic [COUNT_BITS-1:0]   r_point_count;
    logic [COUNT_BITS-1:0]   n_point_count;
    logic [COUNT_BITS-1:0]   count_inc;
    logic                    run_finished;
    logic                    active;
    logic                    mark_ok;

    // Bytes are dropped once the run has its full point count
    assign run_finished = CMP_W'(r_point_count) >= CMP_W'(i_expected_points);
    assign active       = i_byte_valid && !run_finished;
    assign count_inc    = r_point_count + 1'b1;
    assign mark_ok      = (r_end_mark == FRAME_MARK);

    // Next frame position, count and result
    always_comb begin
        n_pos         = r_pos;
        n_point_count = r_point_count;
        o_push        = 1'b0;
        o_push_data.duration    = r_duration;
        o_push_data.frequency   = r_frequency;
        o_push_data.point_index = 16'(r_point_count);
        o_push_data.frame_status = mark_ok ? STATUS_POINT : STATUS_MARK_ERR;
        o_push_data.run_done    = mark_ok && (CMP_W'(count_inc) == CMP_W'(i_expected_points));
        if (active) begin
            case (r_pos)
                POS_HUNT: begin
                    if (i_byte == FRAME_MARK) begin
                        n_pos = POS_DURATION;
                    end
                end
                POS_DURATION: n_pos = POS_FREQ0;
                POS_FREQ0:    n_pos = POS_FREQ1;
                POS_FREQ1:    n_pos = POS_FREQ2;
                POS_FREQ2:    n_pos = POS_FREQ3;
                POS_FREQ3:    n_pos = POS_END_MARK;
                POS_END_MARK: n_pos = POS_CHECKSUM;
                POS_CHECKSUM: begin
                    n_pos  = POS_HUNT;
                    o_push = 1'b1;
                    if (mark_ok) begin
                        n_point_count = count_inc;
                    end
                end
                default: n_pos = POS_HUNT;
            endcase
        end
    end

    // Hold frame position and point count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= POS_HUNT;
            r_point_count <= '0;
        end else begin
            r_pos         <= n_pos;
            r_point_count <= n_point_count;
        end
    end

    // Gather frame bytes into their fields
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duration  <= '0;
            r_frequency <= '0;
            r_end_mark  <= '0;
        end else if (active) begin
            case (r_pos)
                POS_DURATION: r_duration         <= i_byte;
                POS_FREQ0:    r_frequency[7:0]   <= i_byte;
                POS_FREQ1:    r_frequency[15:8]  <= i_byte;
                POS_FREQ2:    r_frequency[23:16] <= i_byte;
                POS_FREQ3:    r_frequency[31:24] <= i_byte;
                POS_END_MARK: r_end_mark         <= i_byte;
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[hw/rtl/mfd_queue.sv]
// Short result queue that decouples the front from the output stage.
`default_nettype none

module mfd_queue
    import mfd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_push_data,
    input  wire logic    i_pop,
    output t_result      o_head,
    output logic         o_empty,
    output logic         o_full
);

    t_result              r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    r_wr_ptr;
    logic [QPTR_W-1:0]    r_rd_ptr;
    logic [QCNT_W-1:0]    r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head  = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Store pushed results
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/mfd_back.sv]
// Back part: output register that delivers queued results downstream.
`default_nettype none

module mfd_back
    import mfd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_empty,
    input  wire t_result i_head,
    output logic         o_pop,
    input  wire logic    i_out_stall,
    output logic         o_out_valid,
    output t_result      o_out_data
);

    logic     r_valid;
    t_result  r_data;

    // Refill the output register when it is free or being taken
    assign o_pop       = !i_empty && (!r_valid || !i_out_stall);
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Load result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_head;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/measurement_frame_deframer.sv]
// Top level of the measurement frame deframer with its configuration port.
//
//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+-------------------------------------
//  rx       | in        | i_rx_valid / o_rx_stall    | i_rx_byte
//  result   | out       | o_res_valid / i_res_stall  | o_frame_status, o_duration,
//           |           |                            | o_frequency, o_point_index, o_run_done
//  config   | in        | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One byte is taken every cycle unless the two-entry result queue is full.
// A result enters the result queue at the edge that takes its checksum byte and
// moves on into the output register once that register is free or being taken.
// Reset starts a new run: hunting for the start marker with a point count of zero.
// o_rx_stall rises only while the queue is full, i.e. after the output has
// been stalled with two more results waiting behind it.
`default_nettype none

module measurement_frame_deframer
    import mfd_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_rx_valid,
    output logic                    o_rx_stall,
    input  wire logic [7:0]         i_rx_byte,
    output logic                    o_res_valid,
    input  wire logic               i_res_stall,
    output logic                    o_frame_status,
    output logic [7:0]              o_duration,
    output logic [31:0]             o_frequency,
    output logic [15:0]             o_point_index,
    output logic                    o_run_done,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [15:0] r_expected_points;
    logic        rx_accept;
    logic        push;
    t_result     push_data;
    t_result     head;
    t_result     out_data;
    logic        q_empty;
    logic        q_full;
    logic        pop;
    logic        sel_expected;

    // Configuration register access
    assign pready       = 1'b1;
    assign sel_expected = (paddr[2] == REG_EXPECTED_IDX);
    assign prdata       = sel_expected ? {16'h0000, r_expected_points} : 32'h0000_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_points <= 16'd1;
        end else if (psel && penable && pwrite && pready && sel_expected) begin
            r_expected_points <= pwdata[15:0];
        end
    end

    // Stall input while the queue has no room
    assign o_rx_stall = q_full;
    assign rx_accept  = i_rx_valid && !q_full;

    mfd_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_byte_valid      (rx_accept),
        .i_byte            (i_rx_byte),
        .i_expected_points (r_expected_points),
        .o_push_data       (push_data),
        .o_push            (push)
    );

    mfd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_empty     (q_empty),
        .o_full      (q_full)
    );

    mfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_head      (head),
        .o_pop       (pop),
        .i_out_stall (i_res_stall),
        .o_out_valid (o_res_valid),
        .o_out_data  (out_data)
    );

    // Break out result fields
    assign o_frame_status = out_data.frame_status;
    assign o_duration     = out_data.duration;
    assign o_frequency    = out_data.frequency;
    assign o_point_index  = out_data.point_index;
    assign o_run_done     = out_data.run_done;

endmodule

`default_nettype wire

[test/tb.sv]
// Testbench for the measurement frame deframer: byte stream in, checked points out.
`timescale 1ns / 100ps

module tb;
    import mfd_pkg::*;

    localparam int unsigned COUNT_BITS = 16;
    localparam logic [PADDR_W-1:0] EXPECTED_ADDR = {REG_EXPECTED_IDX, 2'b00};
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned TARGET_BYTES = 900;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_rx_valid = 1'b0;
    logic        o_rx_stall;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_res_valid;
    logic        i_res_stall = 1'b0;
    logic        o_frame_status;
    logic [7:0]  o_duration;
    logic [31:0] o_frequency;
    logic [15:0] o_point_index;
    logic        o_run_done;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    measurement_frame_deframer #(
        .COUNT_BITS(COUNT_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_valid     (i_rx_valid),
        .o_rx_stall     (o_rx_stall),
        .i_rx_byte      (i_rx_byte),
        .o_res_valid    (o_res_valid),
        .i_res_stall    (i_res_stall),
        .o_frame_status (o_frame_status),
        .o_duration     (o_duration),
        .o_frequency    (o_frequency),
        .o_point_index  (o_point_index),
        .o_run_done     (o_run_done),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Clock: 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Deframer state as the testbench predicts it
    logic [15:0]           expected_cfg = 16'd1;
    t_frame_pos            frame_pos = POS_HUNT;
    logic [7:0]            held_dur = '0;
    logic [31:0]           held_freq = '0;
    logic [7:0]            held_end = '0;
    logic [COUNT_BITS-1:0] point_total = '0;

    logic [7:0] rx_bytes_q[$];
    t_result    pending_points[$];
    int unsigned used_bytes = 0;
    int unsigned mismatch_count = 0;
    bit          rx_accepted = 1'b0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    endtask

    // Advance the predicted deframer by one byte; queue a point on the checksum byte
    task automatic deframe_byte(input logic [7:0] b);
        t_result r;
        used_bytes++;
        if (point_total >= expected_cfg)
            return;
        case (frame_pos)
            POS_HUNT: begin
                if (b == FRAME_MARK)
                    frame_pos = POS_DURATION;
            end
            POS_DURATION: begin
                held_dur = b;
                frame_pos = POS_FREQ0;
            end
            POS_FREQ0, POS_FREQ1, POS_FREQ2, POS_FREQ3: begin
                held_freq[8 * (int'(frame_pos) - int'(POS_FREQ0)) +: 8] = b;
                frame_pos = t_frame_pos'(frame_pos + 3'd1);
            end
            POS_END_MARK: begin
                held_end = b;
                frame_pos = POS_CHECKSUM;
            end
            default: begin
                // checksum byte: consumed, never checked
                frame_pos = POS_HUNT;
                r.duration = held_dur;
                r.frequency = held_freq;
                r.point_index = 16'(point_total);
                if (held_end == FRAME_MARK) begin
                    point_total = point_total + 1'b1;
                    r.frame_status = STATUS_POINT;
                    r.run_done = (point_total == expected_cfg);
                end else begin
                    r.frame_status = STATUS_MARK_ERR;
                    r.run_done = 1'b0;
                end
                pending_points.push_back(r);
            end
        endcase
    endtask

    task automatic check_point();
        t_result want;
        if (pending_points.size() == 0) begin
            report_mismatch("unexpected result, index", o_point_index, 0);
            return;
        end
        want = pending_points.pop_front();
        if (o_frame_status !== want.frame_status)
            report_mismatch("frame_status", o_frame_status, want.frame_status);
        if (o_duration !== want.duration)
            report_mismatch("duration", o_duration, want.duration);
        if (o_frequency !== want.frequency)
            report_mismatch("frequency", o_frequency, want.frequency);
        if (o_point_index !== want.point_index)
            report_mismatch("point_index", o_point_index, want.point_index);
        if (o_run_done !== want.run_done)
            report_mismatch("run_done", o_run_done, want.run_done);
    endtask

    // Monitor: check results and predict accepted bytes at the rising edge
    always @(posedge i_clk) begin
        rx_accepted = 1'b0;
        if (i_rst_n) begin
            if (o_res_valid && !i_res_stall)
                check_point();
            if (i_rx_valid && !o_rx_stall) begin
                rx_accepted = 1'b1;
                deframe_byte(i_rx_byte);
            end
        end
    end

    // Driver: send bytes in bursts with random gaps, hold while stalled
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_rx_valid <= 1'b0;
        end else if (i_rx_valid && !rx_accepted) begin
            // hold the request until it is taken
        end else if (gap_left > 0) begin
            i_rx_valid <= 1'b0;
            gap_left--;
        end else if (rx_bytes_q.size() > 0) begin
            i_rx_valid <= 1'b1;
            i_rx_byte <= rx_bytes_q.pop_front();
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 40);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
        end else begin
            i_rx_valid <= 1'b0;
        end
    end

    // Receiver stall pattern: modes of no stall, scattered stall and long stall runs
    int unsigned stall_mode = 0;
    int unsigned mode_left = 0;
    int unsigned stall_run = 0;

    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: i_res_stall <= 1'b0;
            1: i_res_stall <= ($urandom_range(0, 2) == 0);
            default: begin
                if (stall_run > 0) begin
                    stall_run--;
                    i_res_stall <= 1'b1;
                end else if ($urandom_range(0, 7) == 0) begin
                    stall_run = $urandom_range(1, 12);
                    i_res_stall <= 1'b1;
                end else begin
                    i_res_stall <= 1'b0;
                end
            end
        endcase
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return FRAME_MARK;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_frame(input logic [7:0] dur, input logic [31:0] freq,
                              input logic [7:0] end_mark, input logic [7:0] cks);
        rx_bytes_q.push_back(FRAME_MARK);
        rx_bytes_q.push_back(dur);
        for (int i = 0; i < 4; i++)
            rx_bytes_q.push_back(freq[8 * i +: 8]);
        rx_bytes_q.push_back(end_mark);
        rx_bytes_q.push_back(cks);
    endtask

    // Wait until every byte is taken and every point has come out
    task automatic settle_idle();
        while (rx_bytes_q.size() != 0 || i_rx_valid || pending_points.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the point count, then read it back
    task automatic write_expected(input logic [15:0] value);
        logic [31:0] rd;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= EXPECTED_ADDR;
        pwdata <= {16'h0000, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        expected_cfg = value;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd[15:0] !== value)
            report_mismatch("expected_points readback", rd[15:0], value);
    endtask

    // Random frames: mostly well formed, some bad end markers, noise and cut frames
    task automatic send_frames(input int unsigned n);
        int unsigned len;
        for (int unsigned f = 0; f < n; f++) begin
            case ($urandom_range(0, 99)) inside
                [0:74]:
                    push_frame(pick_byte(), {pick_byte(), pick_byte(), pick_byte(), pick_byte()},
                               FRAME_MARK, pick_byte());
                [75:84]:
                    push_frame(pick_byte(), $urandom, pick_byte(), pick_byte());
                [85:92]: begin
                    len = $urandom_range(1, 5);
                    repeat (len) rx_bytes_q.push_back(pick_byte());
                end
                default: begin
                    len = $urandom_range(1, 6);
                    rx_bytes_q.push_back(FRAME_MARK);
                    repeat (len) rx_bytes_q.push_back(pick_byte());
                end
            endcase
        end
    endtask

    // Stimulus
    initial begin
        int unsigned target;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset count of one: stray bytes, one point that ends the run, then ignored bytes
        rx_bytes_q.push_back(8'h00);
        rx_bytes_q.push_back(8'h55);
        push_frame(8'h00, 32'h0000_0000, FRAME_MARK, 8'h00);
        rx_bytes_q.push_back(FRAME_MARK);
        settle_idle();
        write_expected(16'd1);
        rx_bytes_q.push_back(FRAME_MARK);
        settle_idle();

        // largest count: bad end marker, then a frame full of marker bytes
        write_expected(16'hFFFF);
        push_frame(8'hFF, 32'hFFFF_FFFF, 8'h00, 8'hFF);
        push_frame(FRAME_MARK, 32'hAAAA_AAAA, FRAME_MARK, FRAME_MARK);
        settle_idle();

        // random phases, each under a new point count
        while (used_bytes < TARGET_BYTES) begin
            case ($urandom_range(0, 5))
                0: target = 16'hFFFF;
                1, 2: target = int'(point_total) + $urandom_range(1, 4);
                3: target = $urandom_range(int'(point_total) + 1, 16'hFFFF);
                4: target = (point_total == 0) ? 1 : $urandom_range(1, int'(point_total));
                default: target = 1;
            endcase
            if (target > 16'hFFFF)
                target = 16'hFFFF;
            write_expected(16'(target));
            send_frames($urandom_range(4, 16));
            settle_idle();
        end

        if (pending_points.size() != 0)
            report_mismatch("points never produced", pending_points.size(), 0);
        if (mismatch_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // Watchdog
    initial begin
        #400000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
